### sv/cdq_pkg.sv
// Shared types and constants for the circular deque.
package cdq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned OCC_W  = 4;
  localparam int unsigned OP_W   = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [OCC_W-1:0]         occ_t;

  localparam word_t NONE_WORD = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  // One slot of the row.
  typedef struct packed {
    logic  valid;
    word_t data;
  } cell_state_t;

  // Row-wide command, already qualified by the transaction and legality.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_cmd_t;

endpackage

### sv/cdq_cell.sv
// One cell of the deque row: holds a word and shifts with its neighbors.
module cdq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdq_pkg::cell_cmd_t  cmd_i,
  input  cdq_pkg::word_t      push_value_i,
  input  cdq_pkg::cell_state_t left_i,   // toward the front
  input  cdq_pkg::cell_state_t right_i,  // toward the rear
  output cdq_pkg::cell_state_t state_o,
  output cdq_pkg::cell_state_t next_o
);

  logic           valid_q, valid_d;
  cdq_pkg::word_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (cmd_i.push_front) begin
      valid_d = left_i.valid;
      data_d  = left_i.data;
    end else if (cmd_i.push_rear) begin
      // first empty cell takes the word
      if (!valid_q && left_i.valid) begin
        valid_d = 1'b1;
        data_d  = push_value_i;
      end
    end else if (cmd_i.pop_front) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
    end else if (cmd_i.pop_rear) begin
      // last held cell drops out
      if (valid_q && !right_i.valid) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign state_o = '{valid: valid_q, data: data_q};
  assign next_o  = '{valid: valid_d, data: data_d};

endmodule

### sv/circular_deque.sv
// Top level of the double-ended queue: a row of shifting cells and a result register.
//
// A double-ended queue of up to DEPTH signed 32-bit words. Each input
// transaction carries one operation (push front, push rear, pop front, pop
// rear, query; unused codes act as query) and yields exactly one result
// transaction from a result register. The words sit in a row of
// DEPTH cells with the front in cell 0: a front push or pop shifts every
// cell one place toward its neighbor, a rear push fills the first empty
// cell and a rear pop drops the last held one. So a new transaction is
// taken every cycle as long as the result side takes results; the only
// stall is a result left waiting in the result register while the next
// result is due.
// A push to a full queue or a pop from an empty one is refused
// (accepted = 0, nothing changes, popped_value = -1). front_value and
// rear_value show -1 when the queue is empty; occupancy carries the low
// four bits of the element count. Reset empties the queue at once; no
// clearing pass is needed since the stored words carry no reset.
module circular_deque (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cdq_pkg::OP_W-1:0]   operation_i,
  input  logic signed [31:0]         push_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       accepted_o,
  output logic signed [31:0]         popped_value_o,
  output logic signed [31:0]         front_value_o,
  output logic signed [31:0]         rear_value_o,
  output logic                       is_empty_o,
  output logic                       is_full_o,
  output logic [cdq_pkg::OCC_W-1:0]  occupancy_o
);

  localparam int unsigned N = cdq_pkg::DEPTH;

  // Row state: current and next for each cell, plus valid vectors padded
  // with an always-empty slot past the rear.
  cdq_pkg::cell_state_t cur [N];
  cdq_pkg::cell_state_t nxt [N];
  logic [N:0]           cur_vld;
  logic [N:0]           nxt_vld;

  cdq_pkg::cell_cmd_t cmd;
  cdq_pkg::op_e       op;
  logic               fire;
  logic               is_push, is_pop, push_ok, pop_ok, ok;
  logic               empty_now, full_now;

  cdq_pkg::cnt_t  count_q, count_d;
  cdq_pkg::word_t popped, front_nxt, rear_nxt, rear_cur;

  // Result register
  logic           out_valid_q, out_valid_d;
  logic           acc_q;
  cdq_pkg::word_t popped_q, front_q, rear_q;
  logic           empty_q, full_q;
  cdq_pkg::occ_t  occ_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign empty_now = !cur_vld[0];
  assign full_now  = cur_vld[N-1];

  // Operation decode
  always_comb begin
    op      = cdq_pkg::op_e'(operation_i);
    is_push = 1'b0;
    is_pop  = 1'b0;
    unique case (op)
      cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: is_push = 1'b1;
      cdq_pkg::OP_POP_FRONT,  cdq_pkg::OP_POP_REAR:  is_pop  = 1'b1;
      default: ;  // query and unused codes
    endcase
  end

  assign push_ok = is_push && !full_now;
  assign pop_ok  = is_pop && !empty_now;
  assign ok      = is_push ? push_ok : (is_pop ? pop_ok : 1'b1);

  assign cmd.push_front = fire && push_ok && (op == cdq_pkg::OP_PUSH_FRONT);
  assign cmd.push_rear  = fire && push_ok && (op == cdq_pkg::OP_PUSH_REAR);
  assign cmd.pop_front  = fire && pop_ok  && (op == cdq_pkg::OP_POP_FRONT);
  assign cmd.pop_rear   = fire && pop_ok  && (op == cdq_pkg::OP_POP_REAR);

  // Cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    cdq_pkg::cell_state_t left_s, right_s;

    if (i == 0) begin : g_head
      // the front cell sees the incoming word as its left neighbor
      assign left_s = '{valid: 1'b1, data: push_value_i};
    end else begin : g_mid
      assign left_s = cur[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_s = '{valid: 1'b0, data: cdq_pkg::NONE_WORD};
    end else begin : g_body
      assign right_s = cur[i+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_value_i (push_value_i),
      .left_i       (left_s),
      .right_i      (right_s),
      .state_o      (cur[i]),
      .next_o       (nxt[i])
    );

    assign cur_vld[i] = cur[i].valid;
    assign nxt_vld[i] = nxt[i].valid;
  end
  assign cur_vld[N] = 1'b0;
  assign nxt_vld[N] = 1'b0;

  // Rear word: the one held cell whose right neighbor is empty.
  always_comb begin
    rear_cur = '0;
    rear_nxt = '0;
    for (int i = 0; i < N; i++) begin
      if (cur_vld[i] && !cur_vld[i+1]) rear_cur = rear_cur | cur[i].data;
      if (nxt_vld[i] && !nxt_vld[i+1]) rear_nxt = rear_nxt | nxt[i].data;
    end
  end

  always_comb begin
    popped = cdq_pkg::NONE_WORD;
    if (pop_ok) begin
      popped = (op == cdq_pkg::OP_POP_FRONT) ? cur[0].data : rear_cur;
    end
  end

  assign front_nxt = nxt_vld[0] ? nxt[0].data : cdq_pkg::NONE_WORD;

  // Element count
  always_comb begin
    count_d = count_q;
    if (cmd.push_front || cmd.push_rear) begin
      count_d = count_q + cdq_pkg::cnt_t'(1);
    end else if (cmd.pop_front || cmd.pop_rear) begin
      count_d = count_q - cdq_pkg::cnt_t'(1);
    end
  end

  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q    <= ok;
      popped_q <= popped;
      front_q  <= front_nxt;
      rear_q   <= nxt_vld[0] ? rear_nxt : cdq_pkg::NONE_WORD;
      empty_q  <= !nxt_vld[0];
      full_q   <= nxt_vld[N-1];
      occ_q    <= cdq_pkg::occ_t'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_q;
  assign popped_value_o = popped_q;
  assign front_value_o  = front_q;
  assign rear_value_o   = rear_q;
  assign is_empty_o     = empty_q;
  assign is_full_o      = full_q;
  assign occupancy_o    = occ_q;

endmodule

### sv/cdq_checker.sv
// Port-level checks for the circular deque, bound to the top level.
module cdq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       accepted_o,
  input logic signed [31:0]         popped_value_o,
  input logic signed [31:0]         front_value_o,
  input logic signed [31:0]         rear_value_o,
  input logic                       is_empty_o,
  input logic                       is_full_o,
  input logic [cdq_pkg::OCC_W-1:0]  occupancy_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(front_value_o)
      && $stable(rear_value_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  // A waiting result blocks the input side
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result waits");

  // Empty snapshot is consistent
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> occupancy_o == '0 && !is_full_o
      && front_value_o == cdq_pkg::NONE_WORD && rear_value_o == cdq_pkg::NONE_WORD)
    else $error("empty result inconsistent");

  // Full snapshot reports DEPTH elements
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_full_o |->
      occupancy_o == cdq_pkg::occ_t'(cdq_pkg::DEPTH) && !is_empty_o)
    else $error("full result inconsistent");

  // Refused transactions pop nothing
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> popped_value_o == cdq_pkg::NONE_WORD)
    else $error("refused transaction returned a word");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
